// ----- rtl/tlgs_pkg.sv -----
// Shared types, constants and the cell update rule for the toroidal life core.
// No dependencies; imported by toroidal_life_generation_step_core.
`timescale 1ns / 1ps

package tlgs_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CFG_W    = 7;
    localparam int IDX_W    = 2;
    localparam int MIN_SIZE = 3;

    typedef logic [MAX_COLS-1:0] t_row;
    typedef logic [ROW_W-1:0]    t_row_idx;
    typedef logic [COL_W-1:0]    t_col_idx;
    typedef logic [CFG_W-1:0]    t_cfg;
    typedef logic [IDX_W-1:0]    t_cfg_idx;
    typedef logic [1:0]          t_mode;
    typedef logic [3:0]          t_count;

    localparam t_mode MODE_WRITE   = 2'd0;
    localparam t_mode MODE_READ    = 2'd1;
    localparam t_mode MODE_ADVANCE = 2'd2;
    localparam t_mode MODE_NONE    = 2'd3;

    localparam t_cfg_idx REG_ROWS = 2'd0;
    localparam t_cfg_idx REG_COLS = 2'd1;

    localparam t_cfg ROWS_RESET = t_cfg'(MAX_ROWS);
    localparam t_cfg COLS_RESET = t_cfg'(MAX_COLS);

    localparam t_count BIRTH_COUNT   = 4'd3;
    localparam t_count SURVIVE_COUNT = 4'd2;

    // Size in use: the register value held to the range MIN_SIZE..maxv.
    function automatic t_cfg clamp_size(input t_cfg v, input t_cfg maxv);
        t_cfg res;
        if (v < t_cfg'(MIN_SIZE)) begin
            res = t_cfg'(MIN_SIZE);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // New value of one grid row from the old rows above, at and below it.
    // Columns wrap at nc_m1; columns past it keep their stored values.
    function automatic t_row next_row(input t_row above, input t_row cur,
                                      input t_row below, input t_col_idx nc_m1);
        t_row     res;
        t_col_idx ci;
        t_col_idx li;
        t_col_idx ri;
        t_count   n;
        for (int c = 0; c < MAX_COLS; c++) begin
            ci = t_col_idx'(c);
            li = (ci == '0) ? nc_m1 : t_col_idx'(ci - 1'b1);
            ri = (ci == nc_m1) ? '0 : t_col_idx'(ci + 1'b1);
            n  = t_count'(above[li]) + t_count'(above[ci]) + t_count'(above[ri])
               + t_count'(cur[li])   + t_count'(cur[ri])
               + t_count'(below[li]) + t_count'(below[ci]) + t_count'(below[ri]);
            if (ci > nc_m1) begin
                res[c] = cur[c];
            end else begin
                res[c] = (n == BIRTH_COUNT) || (cur[c] && (n == SURVIVE_COUNT));
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/toroidal_life_generation_step_core.sv -----
// Toroidal B3/S23 life engine: one row-wide grid memory and a row sequencer.
// Depends on tlgs_pkg.
`timescale 1ns / 1ps
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready        | i_mode, i_row, i_col, i_alive_in
//  output   | o_out_valid / i_out_ready      | o_alive_out, o_done_mode
//  config   | i_cfg_we (no wait)             | i_cfg_idx, i_cfg_wdata
//
//  A cell write or read does one grid memory read; a write then writes the row back.
//  An advance moves the single grid memory one row per cycle, and the three-row
//  window is updated across all columns at once.
//  After reset a clearing pass zeroes every grid row; no transfer is taken then.
//  One item is worked on at a time; a result waits in the output register while
//  the next item is taken, and the block stalls only to finish into a full register.

module toroidal_life_generation_step_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tlgs_pkg::t_mode    i_mode,
    input  tlgs_pkg::t_row_idx i_row,
    input  tlgs_pkg::t_col_idx i_col,
    input  logic               i_alive_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_alive_out,
    output tlgs_pkg::t_mode    o_done_mode,
    input  logic               i_cfg_we,
    input  tlgs_pkg::t_cfg_idx i_cfg_idx,
    input  tlgs_pkg::t_cfg     i_cfg_wdata
);
    import tlgs_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR     = 7'b0000001,
        S_IDLE      = 7'b0000010,
        S_ACCESS    = 7'b0000100,
        S_ADV_ABOVE = 7'b0001000,
        S_ADV_FIRST = 7'b0010000,
        S_ADV_CALC  = 7'b0100000,
        S_DONE      = 7'b1000000
    } t_state;

    localparam t_row_idx LAST_ROW = t_row_idx'(MAX_ROWS - 1);

    t_state   r_state, n_state;
    t_mode    r_mode, n_mode;
    t_row_idx r_row, n_row;
    t_col_idx r_col, n_col;
    logic     r_alive, n_alive;
    logic     r_inside, n_inside;
    t_row     r_above, n_above;
    t_row     r_cur, n_cur;
    t_row     r_first, n_first;
    t_row_idx r_ridx, n_ridx;
    logic     r_out_valid, n_out_valid;
    logic     r_out_alive, n_out_alive;
    t_mode    r_out_mode, n_out_mode;
    t_cfg     r_rows_cfg;
    t_cfg     r_cols_cfg;

    t_row     r_grid [MAX_ROWS];
    t_row     r_mem_q;
    logic     mem_we;
    logic     mem_re;
    t_row_idx mem_waddr;
    t_row_idx mem_raddr;
    t_row     mem_wdata;

    t_cfg     eff_rows;
    t_cfg     eff_cols;
    t_row_idx nr_m1;
    t_col_idx nc_m1;
    logic     in_fire;
    logic     slot_free;
    logic     last_row;
    t_row     below_row;
    t_row     patched_row;

    assign eff_rows  = clamp_size(r_rows_cfg, t_cfg'(MAX_ROWS));
    assign eff_cols  = clamp_size(r_cols_cfg, t_cfg'(MAX_COLS));
    assign nr_m1     = t_row_idx'(eff_rows - 1'b1);
    assign nc_m1     = t_col_idx'(eff_cols - 1'b1);
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign last_row    = (r_ridx == nr_m1);
    assign below_row   = last_row ? r_first : r_mem_q;
    assign o_out_valid = r_out_valid;
    assign o_alive_out = r_out_alive;
    assign o_done_mode = r_out_mode;

    always_comb begin
        patched_row        = r_mem_q;
        patched_row[r_col] = r_alive;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_row       = r_row;
        n_col       = r_col;
        n_alive     = r_alive;
        n_inside    = r_inside;
        n_above     = r_above;
        n_cur       = r_cur;
        n_first     = r_first;
        n_ridx      = r_ridx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_alive = r_out_alive;
        n_out_mode  = r_out_mode;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_ridx;
        mem_raddr   = r_row;
        mem_wdata   = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ridx;
                n_ridx    = t_row_idx'(r_ridx + 1'b1);
                if (r_ridx == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_mode   = i_mode;
                    n_row    = i_row;
                    n_col    = i_col;
                    n_alive  = i_alive_in;
                    n_inside = ({1'b0, i_row} < eff_rows) && ({1'b0, i_col} < eff_cols);
                    case (i_mode)
                        MODE_WRITE, MODE_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = i_row;
                            n_state   = S_ACCESS;
                        end
                        MODE_ADVANCE: begin
                            // The row above row 0 is the last row in use.
                            mem_re    = 1'b1;
                            mem_raddr = nr_m1;
                            n_state   = S_ADV_ABOVE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                if (slot_free) begin
                    if ((r_mode == MODE_WRITE) && r_inside) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_row;
                        mem_wdata = patched_row;
                    end
                    n_out_valid = 1'b1;
                    n_out_alive = (r_mode == MODE_READ) && r_inside && r_mem_q[r_col];
                    n_out_mode  = r_mode;
                    n_state     = S_IDLE;
                end
            end
            S_ADV_ABOVE: begin
                n_above   = r_mem_q;
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_state   = S_ADV_FIRST;
            end
            S_ADV_FIRST: begin
                // Row 0 is kept aside: it is overwritten before the last row needs it.
                n_cur     = r_mem_q;
                n_first   = r_mem_q;
                n_ridx    = '0;
                mem_re    = 1'b1;
                mem_raddr = t_row_idx'(1);
                n_state   = S_ADV_CALC;
            end
            S_ADV_CALC: begin
                mem_we    = 1'b1;
                mem_waddr = r_ridx;
                mem_wdata = next_row(r_above, r_cur, below_row, nc_m1);
                if (last_row) begin
                    n_state = S_DONE;
                end else begin
                    // Fetch two rows ahead; the row being written is never the one read.
                    n_above   = r_cur;
                    n_cur     = below_row;
                    n_ridx    = t_row_idx'(r_ridx + 1'b1);
                    mem_re    = 1'b1;
                    mem_raddr = t_row_idx'(r_ridx + 2'd2);
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_alive = 1'b0;
                    n_out_mode  = r_mode;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_grid[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ridx      <= '0;
            r_out_valid <= 1'b0;
            r_rows_cfg  <= ROWS_RESET;
            r_cols_cfg  <= COLS_RESET;
        end else begin
            r_state     <= n_state;
            r_ridx      <= n_ridx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && (i_cfg_idx == REG_ROWS)) begin
                r_rows_cfg <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == REG_COLS)) begin
                r_cols_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_row       <= n_row;
        r_col       <= n_col;
        r_alive     <= n_alive;
        r_inside    <= n_inside;
        r_above     <= n_above;
        r_cur       <= n_cur;
        r_first     <= n_first;
        r_out_alive <= n_out_alive;
        r_out_mode  <= n_out_mode;
    end

`ifndef ASSERT_OFF
    a_no_same_row_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("grid row read and written in the same cycle");

    a_alive_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_done_mode != MODE_READ)) |-> !o_alive_out)
        else $error("live cell reported for a result that is not a read");

    a_row_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV_CALC) |-> (r_ridx <= nr_m1))
        else $error("advance row index beyond the rows in use");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("new transfer taken while an item is in progress");

    a_no_write_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ACCESS) && !r_inside) |-> !mem_we)
        else $error("cell write outside the grid in use");
`endif

endmodule
